// File: src/cale_pkg.sv
package cale_pkg;

    // Store geometry.
    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 64;

    // Request codes.
    localparam logic [3:0] FN_START          = 4'd0;
    localparam logic [3:0] FN_ADVANCE        = 4'd1;
    localparam logic [3:0] FN_INSERT         = 4'd2;
    localparam logic [3:0] FN_ATTACH         = 4'd3;
    localparam logic [3:0] FN_REMOVE         = 4'd4;
    localparam logic [3:0] FN_ADD_FRONT      = 4'd5;
    localparam logic [3:0] FN_REMOVE_FRONT   = 4'd6;
    localparam logic [3:0] FN_ADD_END        = 4'd7;
    localparam logic [3:0] FN_LAST_TO_CURSOR = 4'd8;

    // Error codes.
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_FULL = 2'd1;
    localparam logic [1:0] ERR_NONE = 2'd2;

    typedef struct packed {
        logic [3:0]        func;
        logic [WORD_W-1:0] entry_word;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] current_word;
        logic              has_current;
        logic [7:0]        item_count;
        logic [7:0]        cursor_pos;
        logic [1:0]        error_code;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic shift;
        logic write;
        logic read;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic plan_moves;
        logic plan_write;
        logic last_move;
        logic word_write;
    } t_status;

    // Low eight bits of a count, zero extended when the count is narrower.
    function automatic logic [7:0] to_byte(input logic [CNT_W-1:0] v);
        logic [CNT_W+7:0] w;
        w = {8'd0, v};
        return w[7:0];
    endfunction

endpackage

// File: src/cale_ram.sv
module cale_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/cale_ctrl.sv
module cale_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  cale_pkg::t_status i_status,
    output cale_pkg::t_cmd    o_cmd,
    output logic              busy
);
    import cale_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHIFT = 6'b000010,
        S_DRAIN = 6'b000100,
        S_WRITE = 6'b001000,
        S_READ  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.plan_moves) begin
                        n_state = S_SHIFT;
                    end else if (i_status.plan_write) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.last_move) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last moved word is written in this cycle.
                n_state = i_status.word_write ? S_WRITE : S_READ;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: src/cale_dpath.sv
module cale_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cale_pkg::t_cmd    i_cmd,
    input  cale_pkg::t_req    i_req,
    output cale_pkg::t_status o_status,
    output cale_pkg::t_result o_result
);
    import cale_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_cursor;
    logic [1:0]        r_err;
    logic [CNT_W-1:0]  r_left;
    logic              r_pend;
    logic              r_word_wr;
    logic [CNT_W-1:0]  r_src;
    logic              r_up;
    logic              r_copy;
    logic [ADDR_W-1:0] r_dst;
    logic [ADDR_W-1:0] r_waddr;
    logic [WORD_W-1:0] r_word;

    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  n_cursor;
    logic [1:0]        plan_err;
    logic [CNT_W-1:0]  plan_moves;
    logic [CNT_W-1:0]  plan_src;
    logic [CNT_W-1:0]  plan_gap;
    logic              plan_up;
    logic              plan_copy;
    logic              plan_write;
    logic [ADDR_W-1:0] plan_waddr;

    logic              full;
    logic              item;
    logic [CNT_W-1:0]  src_inc;
    logic [CNT_W-1:0]  src_dec;
    logic [ADDR_W-1:0] dst_addr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    assign full = (r_count == CNT_W'(DEPTH));
    assign item = (r_cursor < r_count);

    // Work out the new count and cursor and the data movement for a request.
    always_comb begin
        n_count    = r_count;
        n_cursor   = r_cursor;
        plan_err   = ERR_OK;
        plan_moves = '0;
        plan_src   = '0;
        plan_gap   = r_cursor;
        plan_up    = 1'b0;
        plan_copy  = 1'b0;
        plan_write = 1'b0;
        plan_waddr = '0;
        case (i_req.func)
            FN_START: begin
                n_cursor = '0;
            end
            FN_ADVANCE: begin
                if (!item) begin
                    plan_err = ERR_NONE;
                end else begin
                    n_cursor = r_cursor + CNT_W'(1);
                end
            end
            FN_INSERT: begin
                if (full) begin
                    plan_err = ERR_FULL;
                end else begin
                    plan_moves = r_count - r_cursor;
                    plan_src   = r_count - CNT_W'(1);
                    plan_up    = 1'b1;
                    plan_write = 1'b1;
                    plan_waddr = r_cursor[ADDR_W-1:0];
                    n_count    = r_count + CNT_W'(1);
                end
            end
            FN_ATTACH: begin
                if (full) begin
                    plan_err = ERR_FULL;
                end else begin
                    plan_gap   = item ? r_cursor + CNT_W'(1) : r_cursor;
                    plan_moves = r_count - plan_gap;
                    plan_src   = r_count - CNT_W'(1);
                    plan_up    = 1'b1;
                    plan_write = 1'b1;
                    plan_waddr = plan_gap[ADDR_W-1:0];
                    n_count    = r_count + CNT_W'(1);
                    n_cursor   = plan_gap;
                end
            end
            FN_REMOVE: begin
                if (!item) begin
                    plan_err = ERR_NONE;
                end else begin
                    plan_moves = r_count - CNT_W'(1) - r_cursor;
                    plan_src   = r_cursor + CNT_W'(1);
                    n_count    = r_count - CNT_W'(1);
                end
            end
            FN_ADD_FRONT: begin
                if (full) begin
                    plan_err = ERR_FULL;
                end else begin
                    plan_moves = r_count;
                    plan_src   = r_count - CNT_W'(1);
                    plan_up    = 1'b1;
                    plan_write = 1'b1;
                    plan_waddr = '0;
                    n_count    = r_count + CNT_W'(1);
                    n_cursor   = '0;
                end
            end
            FN_REMOVE_FRONT: begin
                if (r_count == '0) begin
                    plan_err = ERR_NONE;
                end else begin
                    plan_moves = r_count - CNT_W'(1);
                    plan_src   = CNT_W'(1);
                    n_count    = r_count - CNT_W'(1);
                    n_cursor   = '0;
                end
            end
            FN_ADD_END: begin
                if (full) begin
                    plan_err = ERR_FULL;
                end else begin
                    plan_write = 1'b1;
                    plan_waddr = r_count[ADDR_W-1:0];
                    n_count    = r_count + CNT_W'(1);
                    n_cursor   = r_count;
                end
            end
            FN_LAST_TO_CURSOR: begin
                if (!item) begin
                    plan_err = ERR_NONE;
                end else begin
                    plan_moves = CNT_W'(1);
                    plan_src   = r_count - CNT_W'(1);
                    plan_copy  = 1'b1;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Destination of the word read in this shift cycle.
    assign src_inc  = r_src + CNT_W'(1);
    assign src_dec  = r_src - CNT_W'(1);
    assign dst_addr = r_copy ? r_cursor[ADDR_W-1:0] :
                      r_up   ? src_inc[ADDR_W-1:0]  : src_dec[ADDR_W-1:0];

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cursor  <= '0;
            r_err     <= ERR_OK;
            r_left    <= '0;
            r_pend    <= 1'b0;
            r_word_wr <= 1'b0;
        end else begin
            r_pend <= i_cmd.shift;
            if (i_cmd.accept) begin
                r_count   <= n_count;
                r_cursor  <= n_cursor;
                r_err     <= plan_err;
                r_left    <= plan_moves;
                r_word_wr <= plan_write;
            end else if (i_cmd.shift) begin
                r_left <= r_left - CNT_W'(1);
            end
        end
    end

    // Payload registers of the move sequence.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_src   <= plan_src;
            r_up    <= plan_up;
            r_copy  <= plan_copy;
            r_waddr <= plan_waddr;
            r_word  <= i_req.entry_word;
        end else if (i_cmd.shift) begin
            r_src <= r_up ? src_dec : src_inc;
            r_dst <= dst_addr;
        end
    end

    // A word read in one cycle is written to its new place in the next.
    assign ram_we    = r_pend | i_cmd.write;
    assign ram_waddr = r_pend ? r_dst : r_waddr;
    assign ram_wdata = r_pend ? ram_rdata : r_word;
    assign ram_re    = i_cmd.shift | i_cmd.read;
    assign ram_raddr = i_cmd.shift ? r_src[ADDR_W-1:0] : r_cursor[ADDR_W-1:0];

    cale_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Status for the controller.
    assign o_status.plan_moves = (plan_moves != '0);
    assign o_status.plan_write = plan_write;
    assign o_status.last_move  = (r_left == CNT_W'(1));
    assign o_status.word_write = r_word_wr;

    // Result fields; the store read of the cursor lands in the output cycle.
    assign o_result.current_word = item ? ram_rdata : '0;
    assign o_result.has_current  = item;
    assign o_result.item_count   = to_byte(r_count);
    assign o_result.cursor_pos   = to_byte(r_cursor);
    assign o_result.error_code   = r_err;

endmodule

// File: src/cursor_array_list_engine.sv
// Ordered list of up to DEPTH 64-bit words with a cursor, kept in a single
// RAM with one write and one registered read port. A request is taken when
// start is high and busy is low; busy then stays high until the result,
// which is shown on o_result for exactly one cycle with o_strobe and cannot
// be held off by the receiver. A request moves M stored words one place
// (insert, attach, add front, remove, remove front move the entries past
// the gap; last to cursor moves one; the others move none). The RAM moves
// one word per cycle, so the worst case is an insert or add front that
// moves DEPTH - 1 words. No clearing pass follows reset.
module cursor_array_list_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  cale_pkg::t_req    i_req,
    output logic              busy,
    output logic              o_strobe,
    output cale_pkg::t_result o_result
);
    import cale_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencing of each request.
    cale_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_status(status),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Count, cursor and the entry store.
    cale_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_status(status),
        .o_result(o_result)
    );

    assign o_strobe = cmd.emit;

`ifndef SYNTHESIS
    // An accepted transfer keeps the block busy in the next cycle.
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> busy)
        else $error("block not busy after an accepted transfer");

    // Exactly one result per request, then the block is free again.
    a_strobe_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy && !o_strobe)
        else $error("block still busy after its result");

    // A refused add only happens with a full store.
    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.error_code == ERR_FULL)
            |-> o_result.item_count == to_byte(CNT_W'(DEPTH)))
        else $error("full error reported with a store that is not full");

    // A result without a current item carries a zero word.
    a_no_item_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.has_current |-> o_result.current_word == '0)
        else $error("word reported without a current item");
`endif

endmodule

// File: tb/tb_cursor_array_list_engine.sv
module tb_cursor_array_list_engine;
    import cale_pkg::*;

    // Request codes past the last defined operation are accepted and ignored.
    localparam logic [3:0] FN_UNUSED_LO  = 4'd9;
    localparam logic [3:0] FN_UNUSED_MID = 4'd12;
    localparam logic [3:0] FN_UNUSED_HI  = 4'd15;
    localparam int RANDOM_ITEMS = 1150;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_req    i_req;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    // Shadow copy of the list contents, count and cursor.
    logic [WORD_W-1:0] list_words [DEPTH];
    int                list_count;
    int                list_cursor;

    t_result awaited_reports [$];
    int      mismatch_count;
    int      no_gap_left;

    cursor_array_list_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // Clock with a period of 10 time units.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Safety net in case the block stops responding.
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Move entries at and above pos up by one place.
    task automatic open_gap(input int pos);
        int i;
        for (i = list_count; i > pos; i--) begin
            list_words[i] = list_words[i - 1];
        end
        list_count++;
    endtask

    // Move entries above pos down by one place, dropping the one at pos.
    task automatic close_gap(input int pos);
        int i;
        for (i = pos; i + 1 < list_count; i++) begin
            list_words[i] = list_words[i + 1];
        end
        list_count--;
    endtask

    // Apply one request to the shadow list and build the report it produces.
    task automatic apply_list_request(input t_req req, output t_result rpt);
        logic [1:0] err;
        bit         full;
        bit         has_item;
        err      = ERR_OK;
        full     = (list_count >= DEPTH);
        has_item = (list_cursor < list_count);
        case (req.func)
            FN_START: begin
                list_cursor = 0;
            end
            FN_ADVANCE: begin
                if (!has_item) err = ERR_NONE;
                else list_cursor++;
            end
            FN_INSERT: begin
                if (full) begin
                    err = ERR_FULL;
                end else begin
                    open_gap(list_cursor);
                    list_words[list_cursor] = req.entry_word;
                end
            end
            FN_ATTACH: begin
                if (full) begin
                    err = ERR_FULL;
                end else begin
                    if (has_item) list_cursor++;
                    open_gap(list_cursor);
                    list_words[list_cursor] = req.entry_word;
                end
            end
            FN_REMOVE: begin
                if (!has_item) err = ERR_NONE;
                else close_gap(list_cursor);
            end
            FN_ADD_FRONT: begin
                if (full) begin
                    err = ERR_FULL;
                end else begin
                    open_gap(0);
                    list_words[0] = req.entry_word;
                    list_cursor   = 0;
                end
            end
            FN_REMOVE_FRONT: begin
                if (list_count == 0) begin
                    err = ERR_NONE;
                end else begin
                    list_cursor = 0;
                    close_gap(0);
                end
            end
            FN_ADD_END: begin
                if (full) begin
                    err = ERR_FULL;
                end else begin
                    list_cursor = list_count;
                    list_words[list_cursor] = req.entry_word;
                    list_count++;
                end
            end
            FN_LAST_TO_CURSOR: begin
                if (!has_item) begin
                    err = ERR_NONE;
                end else begin
                    list_words[list_cursor] = list_words[list_count - 1];
                    list_count--;
                end
            end
            default: begin
            end
        endcase
        has_item         = (list_cursor < list_count);
        rpt.current_word = has_item ? list_words[list_cursor] : '0;
        rpt.has_current  = has_item;
        rpt.item_count   = 8'(list_count);
        rpt.cursor_pos   = 8'(list_cursor);
        rpt.error_code   = err;
    endtask

    // Issue one request after a random idle gap and hold start until the
    // transfer happens. Called and left at a falling edge.
    task automatic send_request(input logic [3:0] fn, input logic [WORD_W-1:0] word);
        t_req    req;
        t_result rpt;
        int      gap;
        req.func       = fn;
        req.entry_word = word;
        if (no_gap_left > 0) begin
            no_gap_left--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            no_gap_left = $urandom_range(10, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 13);
        end
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req = req;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        apply_list_request(req, rpt);
        awaited_reports.push_back(rpt);
        @(negedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result with the oldest waiting expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (awaited_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
                mismatch_count++;
            end else begin
                want = awaited_reports.pop_front();
                report_field("current_word", want.current_word, o_result.current_word);
                report_field("has_current", WORD_W'(want.has_current),
                             WORD_W'(o_result.has_current));
                report_field("item_count", WORD_W'(want.item_count),
                             WORD_W'(o_result.item_count));
                report_field("cursor_pos", WORD_W'(want.cursor_pos),
                             WORD_W'(o_result.cursor_pos));
                report_field("error_code", WORD_W'(want.error_code),
                             WORD_W'(o_result.error_code));
            end
        end
    end

    // Refusals on an empty list, ignored codes, and each operation on a
    // short list, including appends when the cursor is past the end.
    task automatic test_directed_cases();
        send_request(FN_REMOVE, '0);
        send_request(FN_ADVANCE, '0);
        send_request(FN_LAST_TO_CURSOR, '0);
        send_request(FN_REMOVE_FRONT, '0);
        send_request(FN_UNUSED_LO, '1);
        send_request(FN_UNUSED_HI, '1);
        send_request(FN_ADD_END, '1);
        send_request(FN_ADD_FRONT, '0);
        send_request(FN_START, '0);
        send_request(FN_INSERT, 64'h8000_0000_0000_0001);
        send_request(FN_ATTACH, 64'h0123_4567_89AB_CDEF);
        send_request(FN_ADVANCE, '0);
        send_request(FN_INSERT, 64'hFEDC_BA98_7654_3210);
        repeat (3) send_request(FN_ADVANCE, '0);
        send_request(FN_ADVANCE, '0);
        send_request(FN_ATTACH, 64'h5555_AAAA_5555_AAAA);
        send_request(FN_ADVANCE, '0);
        send_request(FN_INSERT, 64'hAAAA_5555_AAAA_5555);
        send_request(FN_START, '0);
        send_request(FN_REMOVE, '0);
        send_request(FN_LAST_TO_CURSOR, '0);
        send_request(FN_REMOVE_FRONT, '0);
        send_request(FN_UNUSED_MID, rand_word());
    endtask

    // Fill the store to capacity, try every add while full, then drain it.
    task automatic test_fill_to_capacity();
        logic [3:0] fn;
        while (list_count < DEPTH) begin
            case ($urandom_range(0, 5))
                0: fn = FN_INSERT;
                1: fn = FN_ATTACH;
                2: fn = FN_ADD_FRONT;
                default: fn = FN_ADD_END;
            endcase
            send_request(fn, rand_word());
        end
        send_request(FN_INSERT, rand_word());
        send_request(FN_ATTACH, rand_word());
        send_request(FN_ADD_FRONT, rand_word());
        send_request(FN_ADD_END, rand_word());
        send_request(FN_START, '0);
        send_request(FN_ADVANCE, '0);
        send_request(FN_LAST_TO_CURSOR, '0);
        send_request(FN_ATTACH, rand_word());
        send_request(FN_ATTACH, rand_word());
        while (list_count > 0) begin
            case ($urandom_range(0, 2))
                0: fn = FN_REMOVE;
                1: fn = FN_LAST_TO_CURSOR;
                default: fn = FN_REMOVE_FRONT;
            endcase
            send_request(fn, rand_word());
        end
        send_request(FN_REMOVE_FRONT, '0);
    endtask

    // Random traffic that drifts toward a target length, redrawn now and
    // then, so the list spends time both short and near full.
    task automatic test_random_traffic();
        logic [3:0] fn;
        int         target_len;
        int         add_pct;
        int         drop_pct;
        int         pick;
        target_len = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                case ($urandom_range(0, 3))
                    0: target_len = $urandom_range(0, 8);
                    1: target_len = DEPTH;
                    default: target_len = $urandom_range(0, DEPTH);
                endcase
            end
            add_pct  = (list_count < target_len) ? 50 : 18;
            drop_pct = (list_count < target_len) ? 18 : 50;
            pick     = $urandom_range(0, 99);
            if (pick < add_pct) begin
                case ($urandom_range(0, 3))
                    0: fn = FN_INSERT;
                    1: fn = FN_ATTACH;
                    2: fn = FN_ADD_FRONT;
                    default: fn = FN_ADD_END;
                endcase
            end else if (pick < add_pct + drop_pct) begin
                case ($urandom_range(0, 2))
                    0: fn = FN_REMOVE;
                    1: fn = FN_REMOVE_FRONT;
                    default: fn = FN_LAST_TO_CURSOR;
                endcase
            end else if (pick < add_pct + drop_pct + 28) begin
                fn = ($urandom_range(0, 3) == 0) ? FN_START : FN_ADVANCE;
            end else begin
                fn = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
            end
            send_request(fn, rand_word());
        end
    endtask

    // Reset, run each test in turn, then wait for the last results.
    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req          = '0;
        list_count     = 0;
        list_cursor    = 0;
        mismatch_count = 0;
        no_gap_left    = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_fill_to_capacity();
        test_random_traffic();
        start = 1'b0;

        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
